// ===== rtl/wcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Wolff cluster flip package
// Shared states, codes, command and status bundles and the random step.
// ----------------------------------------------------------------------------
`default_nettype none

package wcf_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SEED_W     = 6;
	localparam int SIZE_W     = 13;
	localparam int SUM_OUT_W  = 14;
	localparam int THR_W      = 16;
	localparam int SIDE_RESET = 30;
	localparam int THR_RESET  = 32768;

	localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED  = 3'd4;

	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SEED_RD,
		ST_SEED_WR,
		ST_POP,
		ST_CUR,
		ST_NB_RD,
		ST_NB_EV,
		ST_FLIP,
		ST_SUM,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RSEL_SEED,
		RSEL_NB,
		RSEL_SWEEP
	} rsel_t;

	typedef struct packed {
		logic  sweep_run;
		logic  sweep_clr;
		logic  init_wr;
		logic  accept;
		logic  seed_wr;
		logic  q_pop;
		logic  cur_load;
		logic  nb_issue;
		logic  nb_eval;
		logic  dir_next;
		logic  flip;
		logic  sum_run;
		rsel_t rsel;
	} cmd_t;

	typedef struct packed {
		logic seed_oor;
		logic sweep_end;
		logic q_empty;
		logic nb_valid;
		logic dir_last;
	} status_t;

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/wcf_ram.sv =====
// ----------------------------------------------------------------------------
// Wolff cluster flip RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wcf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/wcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Wolff cluster flip controller
// Sequences the clearing pass, the cluster growth and the spin-sum sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module wcf_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wcf_pkg::status_t sts,
	output wcf_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	wcf_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcf_pkg::ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wcf_pkg::ST_INIT: begin
				if (sts.sweep_end) state_nxt = wcf_pkg::ST_IDLE;
			end
			wcf_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = sts.seed_oor ? wcf_pkg::ST_SUM : wcf_pkg::ST_SEED_RD;
				end
			end
			wcf_pkg::ST_SEED_RD: state_nxt = wcf_pkg::ST_SEED_WR;
			wcf_pkg::ST_SEED_WR: state_nxt = wcf_pkg::ST_POP;
			wcf_pkg::ST_POP: begin
				state_nxt = sts.q_empty ? wcf_pkg::ST_FLIP : wcf_pkg::ST_CUR;
			end
			wcf_pkg::ST_CUR: state_nxt = wcf_pkg::ST_NB_RD;
			wcf_pkg::ST_NB_RD: begin
				if (sts.nb_valid) begin
					state_nxt = wcf_pkg::ST_NB_EV;
				end else if (sts.dir_last) begin
					state_nxt = wcf_pkg::ST_POP;
				end
			end
			wcf_pkg::ST_NB_EV: begin
				state_nxt = sts.dir_last ? wcf_pkg::ST_POP : wcf_pkg::ST_NB_RD;
			end
			wcf_pkg::ST_FLIP: state_nxt = wcf_pkg::ST_SUM;
			wcf_pkg::ST_SUM: begin
				if (sts.sweep_end) state_nxt = wcf_pkg::ST_DONE;
			end
			wcf_pkg::ST_DONE: state_nxt = wcf_pkg::ST_IDLE;
			default: state_nxt = wcf_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rsel = wcf_pkg::RSEL_NB;
		busy     = 1'b1;
		done     = 1'b0;
		case (state_q)
			wcf_pkg::ST_INIT: begin
				cmd.sweep_run = 1'b1;
				cmd.init_wr   = 1'b1;
			end
			wcf_pkg::ST_IDLE: begin
				busy          = 1'b0;
				cmd.sweep_clr = 1'b1;
				cmd.accept    = start;
			end
			wcf_pkg::ST_SEED_RD: cmd.rsel = wcf_pkg::RSEL_SEED;
			wcf_pkg::ST_SEED_WR: cmd.seed_wr = 1'b1;
			wcf_pkg::ST_POP:     cmd.q_pop = ~sts.q_empty;
			wcf_pkg::ST_CUR:     cmd.cur_load = 1'b1;
			wcf_pkg::ST_NB_RD: begin
				cmd.nb_issue = 1'b1;
				cmd.dir_next = ~sts.nb_valid;
			end
			wcf_pkg::ST_NB_EV: begin
				cmd.nb_eval  = 1'b1;
				cmd.dir_next = 1'b1;
			end
			wcf_pkg::ST_FLIP: cmd.flip = 1'b1;
			wcf_pkg::ST_SUM: begin
				cmd.sweep_run = 1'b1;
				cmd.sum_run   = 1'b1;
				cmd.rsel      = wcf_pkg::RSEL_SWEEP;
			end
			wcf_pkg::ST_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/wcf_dp.sv =====
// ----------------------------------------------------------------------------
// Wolff cluster flip datapath
// Configuration, random generator, spin, visited and queue memories, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module wcf_dp #(
	parameter int MAX_SIDE = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [wcf_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire [wcf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire [wcf_pkg::SEED_W-1:0]          seed_row,
	input  wire [wcf_pkg::SEED_W-1:0]          seed_col,
	input  wcf_pkg::cmd_t                      cmd,
	output wcf_pkg::status_t                   sts,
	output logic [wcf_pkg::SIZE_W-1:0]         cluster_size,
	output logic signed [wcf_pkg::SUM_OUT_W-1:0] spin_sum,
	output logic                               seed_out_of_range
);

	localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int VW    = (SW > 7) ? SW : 7;
	localparam int CMPW  = (SW > wcf_pkg::SEED_W) ? SW : wcf_pkg::SEED_W;
	localparam int CNTW  = AW + 1;
	localparam int SUMW  = AW + 2;
	localparam int SIDE_RST = (MAX_SIDE < wcf_pkg::SIDE_RESET) ? MAX_SIDE : wcf_pkg::SIDE_RESET;

	logic [SW-1:0]             x_size_q, y_size_q, cfg_side;
	logic [VW-1:0]             cfg_side_v;
	logic                      open_q;
	logic [wcf_pkg::THR_W-1:0] thr_q;
	logic [31:0]               rng_q;
	logic [CW-1:0]             seed_r_q, seed_c_q, cur_r_q, cur_c_q, nr, nc;
	logic                      oor_q, seed_spin_q;
	logic [CNTW-1:0]           head_q, tail_q, sw_q;
	logic [1:0]                dir_q;
	logic [AW-1:0]             nb_q, nb_addr, seed_addr, sw_addr;
	logic [SW-1:0]             r1, c1;
	logic                      down_in, up_in, right_in, left_in, nb_valid;
	logic signed [SUMW-1:0]    sum_q;
	logic                      sum_v_s1, sum_in_s1, sw_in;
	logic                      join_nb;

	logic          spin_we, spin_wd, spin_rd;
	logic [AW-1:0] spin_wa, spin_ra;
	logic          vis_we, vis_wd, vis_rd;
	logic [AW-1:0] vis_wa;
	logic          q_we;
	logic [AW-1:0] q_rd;

	assign cfg_side_v = VW'(cfg_wdata[6:0]);

	always_comb begin
		if (cfg_side_v == '0) begin
			cfg_side = SW'(1);
		end else if (cfg_side_v > VW'(MAX_SIDE)) begin
			cfg_side = SW'(MAX_SIDE);
		end else begin
			cfg_side = SW'(cfg_side_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q <= SW'(SIDE_RST);
			y_size_q <= SW'(SIDE_RST);
			open_q   <= 1'b0;
			thr_q    <= wcf_pkg::THR_W'(wcf_pkg::THR_RESET);
			rng_q    <= 32'd1;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					wcf_pkg::CFG_X_SIZE:    x_size_q <= cfg_side;
					wcf_pkg::CFG_Y_SIZE:    y_size_q <= cfg_side;
					wcf_pkg::CFG_BOUNDARY:  open_q   <= cfg_wdata[0];
					wcf_pkg::CFG_THRESHOLD: thr_q    <= cfg_wdata[wcf_pkg::THR_W-1:0];
					wcf_pkg::CFG_RNG_SEED: begin
						rng_q <= (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
					end
					default: open_q <= open_q;
				endcase
			end else if (cmd.nb_issue && nb_valid) begin
				rng_q <= wcf_pkg::xorshift(rng_q);
			end
		end
	end

	assign sts.seed_oor = (CMPW'(seed_row) >= CMPW'(y_size_q)) ||
	                      (CMPW'(seed_col) >= CMPW'(x_size_q));

	// Neighbour of the current site in the direction under test.
	assign r1       = SW'(cur_r_q) + SW'(1);
	assign c1       = SW'(cur_c_q) + SW'(1);
	assign down_in  = r1 < y_size_q;
	assign up_in    = cur_r_q != '0;
	assign right_in = c1 < x_size_q;
	assign left_in  = cur_c_q != '0;

	always_comb begin
		nr       = cur_r_q;
		nc       = cur_c_q;
		nb_valid = 1'b1;
		case (dir_q)
			wcf_pkg::DIR_DOWN: begin
				nr       = down_in ? CW'(r1) : '0;
				nb_valid = ~open_q | down_in;
			end
			wcf_pkg::DIR_UP: begin
				nr       = up_in ? cur_r_q - CW'(1) : CW'(y_size_q - SW'(1));
				nb_valid = ~open_q | up_in;
			end
			wcf_pkg::DIR_RIGHT: begin
				nc       = right_in ? CW'(c1) : '0;
				nb_valid = ~open_q | right_in;
			end
			wcf_pkg::DIR_LEFT: begin
				nc       = left_in ? cur_c_q - CW'(1) : CW'(x_size_q - SW'(1));
				nb_valid = ~open_q | left_in;
			end
			default: nb_valid = 1'b1;
		endcase
	end

	assign nb_addr      = {nr, nc};
	assign seed_addr    = {seed_r_q, seed_c_q};
	assign sw_addr      = sw_q[AW-1:0];
	assign sw_in        = (SW'(sw_addr[AW-1:CW]) < y_size_q) && (SW'(sw_addr[CW-1:0]) < x_size_q);
	assign sts.nb_valid  = nb_valid;
	assign sts.dir_last  = dir_q == wcf_pkg::DIR_LEFT;
	assign sts.q_empty   = head_q == tail_q;
	assign sts.sweep_end = sw_q == CNTW'(DEPTH);

	assign join_nb = (spin_rd == seed_spin_q) && (rng_q[31:16] < thr_q) && !vis_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q     <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			dir_q    <= wcf_pkg::DIR_DOWN;
			oor_q    <= 1'b0;
			sum_q    <= '0;
			sum_v_s1 <= 1'b0;
		end else begin
			if (cmd.sweep_clr) begin
				sw_q <= '0;
			end else if (cmd.sweep_run && !sts.sweep_end) begin
				sw_q <= sw_q + CNTW'(1);
			end
			sum_v_s1 <= cmd.sum_run && !sts.sweep_end;
			if (cmd.accept) begin
				oor_q  <= sts.seed_oor;
				head_q <= '0;
				tail_q <= '0;
				sum_q  <= '0;
			end
			if (cmd.seed_wr) begin
				tail_q <= CNTW'(1);
			end
			if (cmd.q_pop) begin
				head_q <= head_q + CNTW'(1);
			end
			if (cmd.nb_eval && join_nb && tail_q < CNTW'(DEPTH)) begin
				tail_q <= tail_q + CNTW'(1);
			end
			if (cmd.cur_load) begin
				dir_q <= wcf_pkg::DIR_DOWN;
			end else if (cmd.dir_next) begin
				dir_q <= dir_q + 2'd1;
			end
			if (sum_v_s1 && sum_in_s1) begin
				sum_q <= spin_rd ? sum_q + SUMW'(1) : sum_q - SUMW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_in_s1 <= sw_in;
		if (cmd.accept) begin
			seed_r_q <= CW'(seed_row);
			seed_c_q <= CW'(seed_col);
		end
		if (cmd.seed_wr) begin
			seed_spin_q <= spin_rd;
		end
		if (cmd.cur_load) begin
			cur_r_q <= q_rd[AW-1:CW];
			cur_c_q <= q_rd[CW-1:0];
		end
		if (cmd.nb_issue) begin
			nb_q <= nb_addr;
		end
	end

	always_comb begin
		spin_we = 1'b0;
		spin_wa = nb_q;
		spin_wd = ~spin_rd;
		vis_we  = 1'b0;
		vis_wa  = nb_q;
		vis_wd  = 1'b1;
		q_we    = 1'b0;
		if (cmd.init_wr) begin
			spin_we = ~sts.sweep_end;
			spin_wa = sw_addr;
			spin_wd = 1'b1;
			vis_we  = ~sts.sweep_end;
			vis_wa  = sw_addr;
			vis_wd  = 1'b0;
		end else if (cmd.sum_run) begin
			vis_we = ~sts.sweep_end;
			vis_wa = sw_addr;
			vis_wd = 1'b0;
		end else if (cmd.seed_wr) begin
			vis_we = 1'b1;
			vis_wa = seed_addr;
			q_we   = 1'b1;
		end else if (cmd.flip) begin
			spin_we = 1'b1;
			spin_wa = seed_addr;
			spin_wd = ~seed_spin_q;
		end else if (cmd.nb_eval) begin
			spin_we = join_nb;
			vis_we  = join_nb;
			q_we    = join_nb && tail_q < CNTW'(DEPTH);
		end
	end

	always_comb begin
		case (cmd.rsel)
			wcf_pkg::RSEL_SEED:  spin_ra = seed_addr;
			wcf_pkg::RSEL_SWEEP: spin_ra = sw_addr;
			default:             spin_ra = nb_addr;
		endcase
	end

	wcf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_spin (
		.clk   (clk),
		.we    (spin_we),
		.waddr (spin_wa),
		.wdata (spin_wd),
		.raddr (spin_ra),
		.rdata (spin_rd)
	);

	wcf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_wa),
		.wdata (vis_wd),
		.raddr (nb_addr),
		.rdata (vis_rd)
	);

	wcf_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (cmd.seed_wr ? '0 : tail_q[AW-1:0]),
		.wdata (cmd.seed_wr ? seed_addr : nb_q),
		.raddr (head_q[AW-1:0]),
		.rdata (q_rd)
	);

	assign cluster_size      = wcf_pkg::SIZE_W'(tail_q);
	assign spin_sum          = wcf_pkg::SUM_OUT_W'(sum_q);
	assign seed_out_of_range = oor_q;

endmodule

`default_nettype wire

// ===== rtl/wolff_cluster_flip.sv =====
// ----------------------------------------------------------------------------
// Wolff cluster flip
// Ising lattice with breadth-first Wolff cluster updates, one seed a transaction.
// ----------------------------------------------------------------------------
// After reset the lattice is set up by a clearing pass over every site, during
// which busy stays high. After acceptance the seed is read and marked, then the
// cluster grows breadth-first through the queue, each neighbour test taking a read
// state and an evaluate state (open-edge directions are skipped in the read state),
// then a spin-sum sweep of one site a cycle. A seed outside the lattice goes
// straight to the sweep. One transaction at a time; the
`default_nettype none

// result shows for one cycle with done high and the receiver cannot stall it.
module wolff_cluster_flip #(
	parameter int MAX_SIDE = 64
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire [wcf_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  wire [wcf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  wire                                  start,
	output logic                                 busy,
	input  wire [wcf_pkg::SEED_W-1:0]            seed_row,
	input  wire [wcf_pkg::SEED_W-1:0]            seed_col,
	output logic                                 done,
	output logic [wcf_pkg::SIZE_W-1:0]           cluster_size,
	output logic signed [wcf_pkg::SUM_OUT_W-1:0] spin_sum,
	output logic                                 seed_out_of_range
);

	wcf_pkg::cmd_t    cmd;
	wcf_pkg::status_t sts;

	wcf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	wcf_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_wdata         (cfg_wdata),
		.seed_row          (seed_row),
		.seed_col          (seed_col),
		.cmd               (cmd),
		.sts               (sts),
		.cluster_size      (cluster_size),
		.spin_sum          (spin_sum),
		.seed_out_of_range (seed_out_of_range)
	);

endmodule

`default_nettype wire
